// File: design/obb_face_axis_separation_test_unit_assert.svh
// assertion macros for the obb face-axis separation test unit
`ifndef OBB_FACE_AXIS_SEPARATION_TEST_UNIT_ASSERT_SVH
`define OBB_FACE_AXIS_SEPARATION_TEST_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OBBFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obbfs assertion failed");

// next-cycle implication, disabled during reset
`define OBBFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obbfs assertion failed");

`endif

// File: design/obbfs_pkg.sv
// shared types and constants for the obb face-axis separation test unit
package obbfs_pkg;

    typedef logic [2:0] slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF_RD,
        ST_DIFF_SUB,
        ST_ROW_RD,
        ST_MUL,
        ST_DRAIN,
        ST_FOLD,
        ST_CMP,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic       diff_load;
        logic       acc_clr;
        logic       mul_en;
        logic       use_diff;
        logic [1:0] comp;
        logic       hi;
        logic       fold;
        logic       fold_first;
    } mac_ctrl_t;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    localparam int NUM_SLOTS = 8;

    localparam slot_t SLOT_A_CENTER = 3'd0;
    localparam slot_t SLOT_B_CENTER = 3'd4;

    localparam logic [2:0] LAST_AXIS = 3'd5;
    localparam logic [2:0] LAST_TERM = 3'd6;
    localparam logic [2:0] LAST_STEP = 3'd5;

    // half-axis index 0..5 to slot: A half-axes 1..3, B half-axes 5..7
    function automatic slot_t half_slot(input logic [2:0] idx);
        return (idx < 3'd3) ? slot_t'(idx + 3'd1) : slot_t'(idx + 3'd2);
    endfunction

endpackage

// File: design/obbfs_vec_mem.sv
// vector store: eight rows of three coordinates, one write and two registered reads
module obbfs_vec_mem #(
    parameter int COORD_BITS = 32
) (
    input  logic                      clk,
    input  logic                      we,
    input  obbfs_pkg::slot_t          waddr,
    input  logic [3*COORD_BITS-1:0]   wdata,
    input  obbfs_pkg::slot_t          raddr_a,
    input  obbfs_pkg::slot_t          raddr_b,
    output logic [3*COORD_BITS-1:0]   rdata_a,
    output logic [3*COORD_BITS-1:0]   rdata_b
);
    import obbfs_pkg::*;

    localparam int RW = 3 * COORD_BITS;

    logic [RW-1:0] row_mem [NUM_SLOTS];
    logic [RW-1:0] rdata_a_reg;
    logic [RW-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
        rdata_a_reg <= row_mem[raddr_a];
        rdata_b_reg <= row_mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: design/obbfs_mac.sv
// shared multiply-accumulate unit with distance/radius fold and compare
module obbfs_mac #(
    parameter int COORD_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  obbfs_pkg::mac_ctrl_t      ctrl,
    input  logic [3*COORD_BITS-1:0]   row_a,
    input  logic [3*COORD_BITS-1:0]   row_b,
    output logic                      sep
);
    import obbfs_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int LB = CB / 2;
    localparam int HB = CB - LB;
    localparam int MW = HB + 1;
    localparam int PW = DW + MW;
    localparam int AW = 2 * CB + 6;

    logic signed [DW-1:0] diff_reg [3];
    logic signed [PW-1:0] prod_reg;
    logic                 prod_hi_reg;
    logic                 prod_vld_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] dist_reg;
    logic signed [AW-1:0] rad_reg;

    logic [CB-1:0]        a_comp;
    logic [CB-1:0]        b_comp;
    logic signed [DW-1:0] opa;
    logic signed [MW-1:0] opb;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] prod_sh;
    logic signed [AW-1:0] acc_abs;
    logic signed [AW-1:0] rad_minus_dist;

    always_comb
    begin
        unique case (ctrl.comp)
            2'd0:    begin a_comp = row_a[0 +: CB];    b_comp = row_b[0 +: CB];    end
            2'd1:    begin a_comp = row_a[CB +: CB];   b_comp = row_b[CB +: CB];   end
            2'd2:    begin a_comp = row_a[2*CB +: CB]; b_comp = row_b[2*CB +: CB]; end
            default: begin a_comp = row_a[0 +: CB];    b_comp = row_b[0 +: CB];    end
        endcase
    end

    always_comb
    begin
        if (ctrl.use_diff)
        begin
            unique case (ctrl.comp)
                2'd0:    opa = diff_reg[0];
                2'd1:    opa = diff_reg[1];
                2'd2:    opa = diff_reg[2];
                default: opa = diff_reg[0];
            endcase
        end
        else
        begin
            opa = {a_comp[CB-1], a_comp};
        end
        // axis component split into unsigned low half and signed high half
        if (ctrl.hi)
        begin
            opb = {b_comp[CB-1], b_comp[CB-1:LB]};
        end
        else
        begin
            opb = {{(MW-LB){1'b0}}, b_comp[LB-1:0]};
        end
    end

    assign prod     = opa * opb;
    assign prod_ext = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
    assign prod_sh  = prod_hi_reg ? (prod_ext <<< LB) : prod_ext;
    assign acc_abs  = acc_reg[AW-1] ? -acc_reg : acc_reg;
    assign rad_minus_dist = rad_reg - dist_reg;
    assign sep      = rad_minus_dist[AW-1];

    always_ff @(posedge clk)
    begin
        if (ctrl.diff_load)
        begin
            diff_reg[0] <= {row_b[CB-1], row_b[0 +: CB]}
                         - {row_a[CB-1], row_a[0 +: CB]};
            diff_reg[1] <= {row_b[2*CB-1], row_b[CB +: CB]}
                         - {row_a[2*CB-1], row_a[CB +: CB]};
            diff_reg[2] <= {row_b[3*CB-1], row_b[2*CB +: CB]}
                         - {row_a[3*CB-1], row_a[2*CB +: CB]};
        end
        prod_reg    <= prod;
        prod_hi_reg <= ctrl.hi;
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + prod_sh;
        end
        if (ctrl.fold)
        begin
            if (ctrl.fold_first)
            begin
                dist_reg <= acc_abs;
                rad_reg  <= '0;
            end
            else
            begin
                rad_reg <= rad_reg + acc_abs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
        end
    end

endmodule

// File: design/obbfs_seq.sv
// sequencer: axis, term and step counters, handshakes and result register
module obbfs_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 in_test,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 overlap,
    output obbfs_pkg::slot_t     raddr_a,
    output obbfs_pkg::slot_t     raddr_b,
    output obbfs_pkg::mac_ctrl_t ctrl,
    input  logic                 sep
);
    import obbfs_pkg::*;

    seq_state_t state_reg, state_next;
    logic [2:0] axis_reg, axis_next;
    logic [2:0] term_reg, term_next;
    logic [2:0] step_reg, step_next;
    logic       result_reg, result_next;
    logic       out_valid_reg, out_valid_next;
    logic       overlap_reg, overlap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            term_reg      <= '0;
            step_reg      <= '0;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            overlap_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            term_reg      <= term_next;
            step_reg      <= step_next;
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
            overlap_reg   <= overlap_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        term_next      = term_reg;
        step_next      = step_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        overlap_next   = overlap_reg;
        in_ready       = 1'b0;
        raddr_a        = half_slot(term_reg - 3'd1);
        raddr_b        = half_slot(axis_reg);
        ctrl            = '0;
        ctrl.use_diff   = (term_reg == 3'd0);
        ctrl.comp       = step_reg[2:1];
        ctrl.hi         = step_reg[0];
        ctrl.fold_first = (term_reg == 3'd0);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire && in_test)
                begin
                    state_next = ST_DIFF_RD;
                end
            end
            ST_DIFF_RD:
            begin
                raddr_a    = SLOT_A_CENTER;
                raddr_b    = SLOT_B_CENTER;
                state_next = ST_DIFF_SUB;
            end
            ST_DIFF_SUB:
            begin
                ctrl.diff_load = 1'b1;
                axis_next      = '0;
                term_next      = '0;
                state_next     = ST_ROW_RD;
            end
            ST_ROW_RD:
            begin
                ctrl.acc_clr = 1'b1;
                step_next    = '0;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                if (term_reg == LAST_TERM)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = ST_ROW_RD;
                end
            end
            ST_CMP:
            begin
                priority if (sep)
                begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else if (axis_reg == LAST_AXIS)
                begin
                    result_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 3'd1;
                    term_next  = '0;
                    state_next = ST_ROW_RD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    overlap_next   = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign overlap   = overlap_reg;

endmodule

// File: design/obb_face_axis_separation_test_unit.sv
// top level of the obb face-axis separation test unit
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, func, slot, vec_x/y/z | in
//  output  | out_valid, out_ready, overlap             | out
//
// a load transaction writes one row of the vector store
// a test transaction tries n axes, n = 1..6, and ends at the first separating axis
// each axis costs 7 dot products (read, 6 multiplies, drain, fold) and a compare
// reset clears only control state; vector store contents are undefined until loaded
// the finished result waits in an output register; input is taken again meanwhile
// a later test holds in its last cycle until that register is free
module obb_face_axis_separation_test_unit #(
    parameter int COORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [2:0]  slot,
    input  logic [31:0] vec_x,
    input  logic [31:0] vec_y,
    input  logic [31:0] vec_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        overlap
);
    import obbfs_pkg::*;

    localparam int RW = 3 * COORD_BITS;

    logic          in_fire;
    logic          in_test;
    logic          mem_we;
    logic [63:0]   x_ext;
    logic [63:0]   y_ext;
    logic [63:0]   z_ext;
    logic [RW-1:0] wdata;
    logic [RW-1:0] row_a;
    logic [RW-1:0] row_b;
    slot_t         raddr_a;
    slot_t         raddr_b;
    mac_ctrl_t     mac_ctrl;
    logic          sep;

    assign in_fire = in_valid && in_ready;
    assign in_test = (func == FUNC_TEST);
    assign mem_we  = in_fire && (func == FUNC_LOAD);

    assign x_ext = {{32{vec_x[31]}}, vec_x};
    assign y_ext = {{32{vec_y[31]}}, vec_y};
    assign z_ext = {{32{vec_z[31]}}, vec_z};
    assign wdata = {z_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0], x_ext[COORD_BITS-1:0]};

    obbfs_vec_mem #(
        .COORD_BITS (COORD_BITS)
    ) u_vec_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (slot),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (row_a),
        .rdata_b (row_b)
    );

    obbfs_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .row_a (row_a),
        .row_b (row_b),
        .sep   (sep)
    );

    obbfs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_test   (in_test),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .overlap   (overlap),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b),
        .ctrl      (mac_ctrl),
        .sep       (sep)
    );

`include "obb_face_axis_separation_test_unit_assert.svh"

    // a test transaction keeps the block busy
`OBBFS_ASSERT_NEXT(a_test_busy, in_fire && in_test, !in_ready)
    // a load transaction never produces a result
`OBBFS_ASSERT_NEXT(a_load_no_result, in_fire && !in_test && !out_valid, !out_valid)
    // the multiplier never runs while input is open
`OBBFS_ASSERT_NOW(a_idle_no_mul, in_ready, !mac_ctrl.mul_en)

endmodule
